>>> sv/dsra_pkg.sv
// Package for the drawing-script register ALU: codes, sizes and the
// request/response structs between the sequencer and the ALU. No dependencies.
package dsra_pkg;

  localparam int NUM_REGS_DEF = 16;
  localparam int WORD_W = 16;
  localparam int CFG_NUM = 8;
  localparam int CFG_AW = 3;

  localparam logic [WORD_W-1:0] CALC_BASE = 16'hFF00;
  localparam logic [WORD_W-1:0] CALC_LAST = 16'hFF0F;

  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_VAR_IMM  = 3'd1;
  localparam logic [2:0] MODE_VAR_CALC = 3'd2;
  localparam logic [2:0] MODE_DEFAULTS = 3'd3;
  localparam logic [2:0] MODE_DRAW     = 3'd4;

  localparam logic [2:0] KIND_FILL_RECT = 3'd0;
  localparam logic [2:0] KIND_DRAW_RECT = 3'd1;
  localparam logic [2:0] KIND_HLINE     = 3'd2;
  localparam logic [2:0] KIND_VLINE     = 3'd3;
  localparam logic [2:0] KIND_TEXT      = 3'd4;
  localparam logic [2:0] KIND_BITMAP    = 3'd5;

  localparam logic [3:0] OP_SET   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_AND   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_XOR   = 4'd7;
  localparam logic [3:0] OP_SHL   = 4'd8;
  localparam logic [3:0] OP_SHR   = 4'd9;
  localparam logic [3:0] OP_MOD   = 4'd10;
  localparam logic [3:0] OP_NOT   = 4'd11;
  localparam logic [3:0] OP_NEG   = 4'd12;
  localparam logic [3:0] OP_SLIDE = 4'd13;
  localparam logic [3:0] OP_REG   = 4'd14;
  localparam logic [3:0] OP_NONE  = 4'd15;

  typedef struct packed {
    logic              start;
    logic [3:0]        op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

>>> sv/draw_script_register_alu.sv
// Drawing-script register ALU: one request at a time runs against a 16x16 register
// file held in a RAM with one read port; each read has a request and a wait state.
// Start and defaults load four registers from the settings, a draw of an unknown kind
// yields no command, and div or mod use the 16-step divider. in_ready
// is high only when idle; a finished draw command waits in the output register, and a
// draw or bad operand waits in its last step while that register is still full.
// Depends on dsra_pkg, dsra_ram and dsra_alu.
module draw_script_register_alu
  import dsra_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [2:0]         in_draw_kind,
  input  logic [3:0]         in_target_reg,
  input  logic [3:0]         in_alu_op,
  input  logic [15:0]        in_operand_word,
  input  logic [15:0]        in_coord_x,
  input  logic [15:0]        in_coord_y,
  input  logic [15:0]        in_size_w,
  input  logic [15:0]        in_size_h,
  input  logic [31:0]        in_color,
  input  logic [31:0]        in_text_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_cmd_kind,
  output logic [15:0]        out_pos_x,
  output logic [15:0]        out_pos_y,
  output logic [15:0]        out_extent_w,
  output logic [15:0]        out_extent_h,
  output logic [31:0]        out_cmd_color,
  output logic [31:0]        out_cmd_flags,
  output logic               out_fault
);

  localparam int REG_AW = $clog2(NUM_REGS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_OPND    = 4'd2;
  localparam logic [3:0] S_OPND_W  = 4'd3;
  localparam logic [3:0] S_CUR     = 4'd4;
  localparam logic [3:0] S_CUR_W   = 4'd5;
  localparam logic [3:0] S_SRC     = 4'd6;
  localparam logic [3:0] S_SRC_W   = 4'd7;
  localparam logic [3:0] S_SLIDE   = 4'd8;
  localparam logic [3:0] S_SLIDE_W = 4'd9;
  localparam logic [3:0] S_EXEC    = 4'd10;
  localparam logic [3:0] S_BUSY    = 4'd11;
  localparam logic [3:0] S_WB      = 4'd12;
  localparam logic [3:0] S_CALC    = 4'd13;
  localparam logic [3:0] S_CALC_W  = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  // request fields
  logic [2:0]  mode_r;
  logic [2:0]  kind_r;
  logic [REG_AW-1:0] tgt_r;
  logic [15:0] opnd_r;
  logic [15:0] cx_r, cy_r, sw_r, sh_r;
  logic [31:0] color_r, flags_r;

  logic [WORD_W-1:0] cfg_r [CFG_NUM];

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              is_def_r, is_def_nxt;
  logic [3:0]        op_r, op_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] slot_r [4];
  logic [WORD_W-1:0] slot_nxt [4];
  logic              bad_r, bad_nxt;
  logic [NUM_REGS-1:0] valid_r, valid_nxt;
  logic [REG_AW-1:0] rd_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [15:0]       out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [15:0]       out_w_r, out_w_nxt, out_h_r, out_h_nxt;
  logic [31:0]       out_color_r, out_color_nxt, out_flags_r, out_flags_nxt;
  logic              out_fault_r, out_fault_nxt;

  logic              ram_we, ram_re;
  logic [REG_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [WORD_W-1:0] rvalue;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic              in_fire;
  logic [15:0]       calc_word;
  logic              calc_resolve;
  logic              rect_kind;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rvalue   = valid_r[rd_addr_r] ? ram_rdata : '0;
  assign rect_kind = (kind_r == KIND_FILL_RECT) || (kind_r == KIND_DRAW_RECT) ||
                     (kind_r == KIND_BITMAP);
  assign calc_resolve = !cnt_r[1] || rect_kind;

  always_comb begin
    unique case (cnt_r)
      2'd0:    calc_word = cx_r;
      2'd1:    calc_word = cy_r;
      2'd2:    calc_word = sw_r;
      default: calc_word = sh_r;
    endcase
  end

  dsra_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_REGS)
  ) u_regs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dsra_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .rsp  (alu_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_def_nxt    = is_def_r;
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    slot_nxt      = slot_r;
    bad_nxt       = bad_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_w_nxt     = out_w_r;
    out_h_nxt     = out_h_r;
    out_color_nxt = out_color_r;
    out_flags_nxt = out_flags_r;
    out_fault_nxt = out_fault_r;
    ram_we        = 1'b0;
    ram_waddr     = tgt_r;
    ram_wdata     = res_r;
    ram_re        = 1'b0;
    ram_raddr     = tgt_r;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_req.a     = cur_r;
    alu_req.b     = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_alu_op;
          val_nxt = in_operand_word;
          cnt_nxt = '0;
          bad_nxt = 1'b0;
          unique case (in_mode)
            MODE_START: begin
              valid_nxt  = '0;
              is_def_nxt = 1'b0;
              state_nxt  = S_INIT;
            end
            MODE_DEFAULTS: begin
              is_def_nxt = 1'b1;
              state_nxt  = S_INIT;
            end
            MODE_VAR_IMM:  state_nxt = S_CUR;
            MODE_VAR_CALC: state_nxt = S_OPND;
            MODE_DRAW:     state_nxt = (in_draw_kind > KIND_BITMAP) ? S_IDLE : S_CALC;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = REG_AW'(cnt_r);
        ram_wdata = cfg_r[{is_def_r, cnt_r}];
        valid_nxt[REG_AW'(cnt_r)] = 1'b1;
        cnt_nxt   = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_IDLE;
        end
      end
      S_OPND: begin
        if (opnd_r < CALC_BASE) begin
          state_nxt = S_CUR;
        end else if (opnd_r <= CALC_LAST) begin
          ram_re    = 1'b1;
          ram_raddr = opnd_r[REG_AW-1:0];
          state_nxt = S_OPND_W;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_OPND_W: begin
        val_nxt   = rvalue;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        ram_re    = 1'b1;
        state_nxt = S_CUR_W;
      end
      S_CUR_W: begin
        cur_nxt = rvalue;
        unique case (op_r)
          OP_REG:   state_nxt = S_SRC;
          OP_SLIDE: state_nxt = S_SLIDE;
          OP_NONE:  state_nxt = S_IDLE;
          default:  state_nxt = S_EXEC;
        endcase
      end
      S_SRC: begin
        ram_re    = 1'b1;
        ram_raddr = val_r[REG_AW-1:0];
        state_nxt = S_SRC_W;
      end
      S_SRC_W: begin
        val_nxt = rvalue;
        op_nxt  = val_r[7:4];
        unique case (val_r[7:4])
          OP_REG, OP_NONE: state_nxt = S_IDLE;
          OP_SLIDE:        state_nxt = S_SLIDE;
          default:         state_nxt = S_EXEC;
        endcase
      end
      S_SLIDE: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_r - REG_AW'(1);
        state_nxt = S_SLIDE_W;
      end
      S_SLIDE_W: begin
        res_nxt   = rvalue;
        state_nxt = S_WB;
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
        state_nxt     = S_BUSY;
      end
      S_BUSY: begin
        if (alu_rsp.done) begin
          res_nxt   = alu_rsp.result;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        ram_we           = 1'b1;
        valid_nxt[tgt_r] = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_CALC: begin
        if (!calc_resolve) begin
          // lines carry a plain length and no height; text has no extent
          slot_nxt[cnt_r] = (cnt_r == 2'd2 && kind_r != KIND_TEXT) ? sw_r : '0;
        end else if (calc_word < CALC_BASE) begin
          slot_nxt[cnt_r] = calc_word;
        end else if (calc_word > CALC_LAST) begin
          slot_nxt[cnt_r] = '0;
          bad_nxt         = 1'b1;
        end
        if (calc_resolve && calc_word >= CALC_BASE && calc_word <= CALC_LAST) begin
          ram_re    = 1'b1;
          ram_raddr = calc_word[REG_AW-1:0];
          state_nxt = S_CALC_W;
        end else begin
          cnt_nxt   = cnt_r + 2'd1;
          state_nxt = (cnt_r == 2'd3) ? S_EMIT : S_CALC;
        end
      end
      S_CALC_W: begin
        slot_nxt[cnt_r] = rvalue;
        cnt_nxt         = cnt_r + 2'd1;
        state_nxt       = (cnt_r == 2'd3) ? S_EMIT : S_CALC;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (mode_r == MODE_VAR_CALC) begin
            out_kind_nxt  = '0;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_w_nxt     = '0;
            out_h_nxt     = '0;
            out_color_nxt = '0;
            out_flags_nxt = '0;
            out_fault_nxt = 1'b1;
          end else begin
            out_kind_nxt  = kind_r;
            out_x_nxt     = slot_r[0];
            out_y_nxt     = slot_r[1];
            out_w_nxt     = slot_r[2];
            out_h_nxt     = slot_r[3];
            out_color_nxt = (kind_r == KIND_BITMAP) ? '0 : color_r;
            out_flags_nxt = (kind_r == KIND_TEXT) ? flags_r : '0;
            out_fault_nxt = bad_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r[cfg_index] <= cfg_data;
      end
    end
    is_def_r    <= is_def_nxt;
    op_r        <= op_nxt;
    cur_r       <= cur_nxt;
    val_r       <= val_nxt;
    res_r       <= res_nxt;
    slot_r      <= slot_nxt;
    bad_r       <= bad_nxt;
    out_kind_r  <= out_kind_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_w_r     <= out_w_nxt;
    out_h_r     <= out_h_nxt;
    out_color_r <= out_color_nxt;
    out_flags_r <= out_flags_nxt;
    out_fault_r <= out_fault_nxt;
    if (ram_re) begin
      rd_addr_r <= ram_raddr;
    end
    if (in_fire) begin
      mode_r  <= in_mode;
      kind_r  <= in_draw_kind;
      tgt_r   <= in_target_reg[REG_AW-1:0];
      opnd_r  <= in_operand_word;
      cx_r    <= in_coord_x;
      cy_r    <= in_coord_y;
      sw_r    <= in_size_w;
      sh_r    <= in_size_h;
      color_r <= in_color;
      flags_r <= in_text_flags;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cmd_kind  = out_kind_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_extent_w  = out_w_r;
  assign out_extent_h  = out_h_r;
  assign out_cmd_color = out_color_r;
  assign out_cmd_flags = out_flags_r;
  assign out_fault     = out_fault_r;

endmodule

>>> sv/dsra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> sv/dsra_alu.sv
// 16-bit ALU: simple ops with a registered result plus a 16-step restoring divider for
// div and mod. Depends on dsra_pkg.
module dsra_alu
  import dsra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] div_b_r, div_b_nxt;
  logic              is_mod_r, is_mod_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;

  logic [WORD_W-1:0] simple_res;
  logic [2*WORD_W-1:0] prod;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_step;
  logic [WORD_W-1:0] quo_step;

  assign prod = req.a * req.b;

  always_comb begin
    unique case (req.op)
      OP_SET:  simple_res = req.b;
      OP_ADD:  simple_res = req.a + req.b;
      OP_SUB:  simple_res = req.a - req.b;
      OP_MUL:  simple_res = prod[WORD_W-1:0];
      OP_AND:  simple_res = req.a & req.b;
      OP_OR:   simple_res = req.a | req.b;
      OP_XOR:  simple_res = req.a ^ req.b;
      OP_SHL:  simple_res = (req.b >= 16'd16) ? '0 : (req.a << req.b[3:0]);
      OP_SHR:  simple_res = (req.b >= 16'd16) ? '0 : (req.a >> req.b[3:0]);
      OP_NOT:  simple_res = (req.a == '0) ? 16'd1 : '0;
      OP_NEG:  simple_res = '0 - req.a;
      default: simple_res = '0;  // div/mod by zero, or unused codes
    endcase
  end

  assign shifted  = {rem_r, quo_r[WORD_W-1]};
  assign diff     = shifted - {1'b0, div_b_r};
  assign rem_step = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
  assign quo_step = {quo_r[WORD_W-2:0], ~diff[WORD_W]};

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    div_b_nxt  = div_b_r;
    is_mod_nxt = is_mod_r;
    res_nxt    = res_r;
    if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = is_mod_r ? rem_step : quo_step;
      end
    end else if (req.start) begin
      if ((req.op == OP_DIV || req.op == OP_MOD) && req.b != '0) begin
        busy_nxt   = 1'b1;
        cnt_nxt    = 5'(WORD_W);
        rem_nxt    = '0;
        quo_nxt    = req.a;
        div_b_nxt  = req.b;
        is_mod_nxt = (req.op == OP_MOD);
      end else begin
        done_nxt = 1'b1;
        res_nxt  = simple_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    div_b_r  <= div_b_nxt;
    is_mod_r <= is_mod_nxt;
    res_r    <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

>>> tb/draw_script_register_alu_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for draw_script_register_alu: a directed script table followed by
// random script requests under several pacing modes, checked against an in-bench predictor.
// Depends on dsra_pkg and the draw_script_register_alu RTL.
module draw_script_register_alu_test
  import dsra_pkg::*;
();

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int NUM_DIRECTED = 29;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef enum logic [CFG_AW-1:0] {
    WINDOW_WIDTH, WINDOW_HEIGHT, WINDOW_LEFT, WINDOW_TOP,
    SURFACE_WIDTH, SURFACE_HEIGHT, SHIFT_X, SHIFT_Y
  } cfg_reg_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  kind;
    logic [3:0]  tgt;
    logic [3:0]  op;
    logic [15:0] operand;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] color;
    logic [31:0] flags;
  } script_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] ew;
    logic [15:0] eh;
    logic [31:0] color;
    logic [31:0] flags;
    logic        fault;
  } draw_cmd_t;

  typedef struct packed {
    script_item_t item;
    logic         typed;
    draw_cmd_t    cmd;
  } script_row_t;

  typedef struct packed {
    logic        bad;
    logic [15:0] value;
  } calc_val_t;

  typedef logic [0:CFG_NUM-1][WORD_W-1:0] cfg_set_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_mode;
  logic [2:0] in_draw_kind;
  logic [3:0] in_target_reg;
  logic [3:0] in_alu_op;
  logic [15:0] in_operand_word;
  logic [15:0] in_coord_x;
  logic [15:0] in_coord_y;
  logic [15:0] in_size_w;
  logic [15:0] in_size_h;
  logic [31:0] in_color;
  logic [31:0] in_text_flags;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_cmd_kind;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [15:0] out_extent_w;
  logic [15:0] out_extent_h;
  logic [31:0] out_cmd_color;
  logic [31:0] out_cmd_flags;
  logic out_fault;

  logic [15:0] shadow_regs [NUM_REGS_DEF];
  logic [15:0] shadow_cfg [CFG_NUM];
  draw_cmd_t pending_draw_cmds [$];
  idle_e idle_mode = IDLE_NONE;
  int errors = 0;
  int items_sent = 0;
  int cmds_checked = 0;
  int faults_seen = 0;
  int cycle_count = 0;

  script_row_t script_table [NUM_DIRECTED] = '{
    '{'{MODE_DRAW, KIND_FILL_RECT, 4'd0, OP_NONE, 16'h0000, 16'hFF00, 16'hFF0F, 16'hFF08,
        16'hFF03, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{KIND_FILL_RECT, 16'h0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b0}},
    '{'{MODE_UNUSED, KIND_FILL_RECT, 4'd1, OP_SET, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_START, KIND_FILL_RECT, 4'd0, OP_SET, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_DRAW_RECT, 4'd0, OP_NONE, 16'h0, 16'hFF00, 16'hFF01, 16'hFF02,
        16'hFF03, 32'h0, 32'hFFFF_FFFF}, 1'b1,
      '{KIND_DRAW_RECT, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 32'h0, 32'h0, 1'b0}},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd15, OP_SET, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd15, OP_ADD, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd4, OP_SUB, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd4, OP_MUL, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd0, OP_DIV, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd1, OP_MOD, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd3, OP_AND, 16'h0F0F, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd5, OP_OR, 16'hF000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd5, OP_XOR, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd5, OP_SHL, 16'h000F, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd3, OP_SHR, 16'h0010, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd6, OP_NOT, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd6, OP_NEG, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd0, OP_SLIDE, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd7, OP_REG, 16'hAB14, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd7, OP_REG, 16'h00E5, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_IMM, KIND_FILL_RECT, 4'd7, OP_NONE, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_CALC, KIND_FILL_RECT, 4'd5, OP_DIV, 16'hFF07, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_VAR_CALC, KIND_FILL_RECT, 4'd2, OP_SET, 16'hFF10, 16'hFF01, 16'hFF02, 16'h0,
        16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{KIND_FILL_RECT, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 1'b1}},
    '{'{MODE_DEFAULTS, KIND_FILL_RECT, 4'd0, OP_SET, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
        32'h0, 32'h0}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_HLINE, 4'd0, OP_SET, 16'h0, 16'hFF00, 16'hFFFF, 16'hFF07, 16'h1234,
        32'h8000_0001, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_VLINE, 4'd0, OP_SET, 16'h0, 16'hFEFF, 16'hFF02, 16'h0000, 16'hFFFF,
        32'h7FFF_FFFE, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_TEXT, 4'd0, OP_SET, 16'h0, 16'hFF05, 16'hFF06, 16'hFF00, 16'hFF01,
        32'h1234_5678, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_BITMAP, 4'd0, OP_SET, 16'h0, 16'hFF01, 16'hFF02, 16'hFF03, 16'hFF00,
        32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{MODE_DRAW, KIND_UNUSED, 4'd0, OP_SET, 16'h0, 16'hFF00, 16'hFF01, 16'h0, 16'h0,
        32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0}
  };

  draw_script_register_alu dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic calc_val_t resolve_calc(input logic [15:0] word);
    calc_val_t r;
    r = '0;
    if (word < CALC_BASE) r.value = word;
    else if (word <= CALC_LAST) r.value = shadow_regs[word[3:0]];
    else r.bad = 1'b1;
    return r;
  endfunction

  function automatic void apply_alu(input logic [3:0] tgt, input logic [3:0] op_in,
                                    input logic [15:0] val_in);
    logic [15:0] cur, res, val;
    logic [3:0] op;
    cur = shadow_regs[tgt];
    res = cur;
    op = op_in;
    val = val_in;
    if (op == OP_REG) begin
      op = val[7:4];
      val = shadow_regs[val[3:0]];
    end
    case (op)
      OP_SET:   res = val;
      OP_ADD:   res = cur + val;
      OP_SUB:   res = cur - val;
      OP_MUL:   res = cur * val;
      OP_DIV:   res = (val == 16'd0) ? 16'd0 : cur / val;
      OP_AND:   res = cur & val;
      OP_OR:    res = cur | val;
      OP_XOR:   res = cur ^ val;
      OP_SHL:   res = (val >= 16'd16) ? 16'd0 : cur << val;
      OP_SHR:   res = (val >= 16'd16) ? 16'd0 : cur >> val;
      OP_MOD:   res = (val == 16'd0) ? 16'd0 : cur % val;
      OP_NOT:   res = (cur == 16'd0) ? 16'd1 : 16'd0;
      OP_NEG:   res = 16'd0 - cur;
      OP_SLIDE: res = shadow_regs[tgt - 4'd1];
      default: ;
    endcase
    shadow_regs[tgt] = res;
  endfunction

  // Updates the shadow register file; returns 1 when the request yields a draw command.
  function automatic bit run_script_item(input script_item_t it, output draw_cmd_t cmd);
    calc_val_t rx, ry, rw, rh, rv;
    cmd = '0;
    case (it.mode)
      MODE_START: begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_regs[0] = shadow_cfg[WINDOW_WIDTH];
        shadow_regs[1] = shadow_cfg[WINDOW_HEIGHT];
        shadow_regs[2] = shadow_cfg[WINDOW_LEFT];
        shadow_regs[3] = shadow_cfg[WINDOW_TOP];
      end
      MODE_VAR_IMM: apply_alu(it.tgt, it.op, it.operand);
      MODE_VAR_CALC: begin
        rv = resolve_calc(it.operand);
        if (!rv.bad) apply_alu(it.tgt, it.op, rv.value);
        else begin
          cmd.fault = 1'b1;
          return 1'b1;
        end
      end
      MODE_DEFAULTS: begin
        shadow_regs[0] = shadow_cfg[SURFACE_WIDTH];
        shadow_regs[1] = shadow_cfg[SURFACE_HEIGHT];
        shadow_regs[2] = shadow_cfg[SHIFT_X];
        shadow_regs[3] = shadow_cfg[SHIFT_Y];
      end
      MODE_DRAW: begin
        if (it.kind > KIND_BITMAP) return 1'b0;
        rx = resolve_calc(it.x);
        ry = resolve_calc(it.y);
        cmd.kind = it.kind;
        cmd.px = rx.value;
        cmd.py = ry.value;
        cmd.fault = rx.bad | ry.bad;
        if (it.kind == KIND_FILL_RECT || it.kind == KIND_DRAW_RECT
            || it.kind == KIND_BITMAP) begin
          rw = resolve_calc(it.w);
          rh = resolve_calc(it.h);
          cmd.ew = rw.value;
          cmd.eh = rh.value;
          cmd.fault = cmd.fault | rw.bad | rh.bad;
        end else if (it.kind == KIND_HLINE || it.kind == KIND_VLINE) begin
          cmd.ew = it.w;
        end
        if (it.kind != KIND_BITMAP) cmd.color = it.color;
        if (it.kind == KIND_TEXT) cmd.flags = it.flags;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [15:0] rand_calc_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return CALC_BASE | 16'($urandom_range(15));
    if (pick < 49) return 16'($urandom_range(16'hFFFF, 16'hFF10));
    if (pick < 53) return pick[0] ? 16'hFEFF : 16'h0000;
    return 16'($urandom_range(16'hFEFF));
  endfunction

  function automatic logic [15:0] rand_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 16'($urandom_range(20));
    if (pick < 40) return 16'h0000;
    if (pick < 50) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic script_item_t random_item();
    script_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.kind = ($urandom_range(99) < 94) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
    it.tgt = 4'($urandom);
    it.op = 4'($urandom);
    it.operand = rand_operand();
    it.x = rand_calc_word();
    it.y = rand_calc_word();
    it.w = rand_calc_word();
    it.h = rand_calc_word();
    it.color = $urandom;
    it.flags = $urandom;
    if (pick < 5) it.mode = MODE_START;
    else if (pick < 10) it.mode = MODE_DEFAULTS;
    else if (pick < 35) it.mode = MODE_VAR_IMM;
    else if (pick < 50) begin
      it.mode = MODE_VAR_CALC;
      it.operand = rand_calc_word();
    end else if (pick < 97) it.mode = MODE_DRAW;
    else it.mode = 3'($urandom_range(7, 5));
    return it;
  endfunction

  function automatic cfg_set_t phase_settings(input int phase);
    cfg_set_t vals;
    int i, pick;
    for (i = 0; i < CFG_NUM; i++) begin
      pick = $urandom_range(3);
      if (phase == 0) vals[i] = 16'h0000;
      else if (phase == 1) vals[i] = 16'hFFFF;
      else if (pick == 0) vals[i] = 16'h0000;
      else if (pick == 1) vals[i] = 16'hFFFF;
      else vals[i] = 16'($urandom);
    end
    return vals;
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 86;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 24;
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    if (idle_mode == IDLE_RECEIVER) out_ready <= $urandom_range(99) >= 86;
    else if (idle_mode == IDLE_BOTH) out_ready <= $urandom_range(99) >= 24;
    else out_ready <= 1'b1;
  end

  // Called at a falling edge while idle; returns at a falling edge.
  task automatic load_settings(input cfg_set_t vals);
    int i;
    for (i = 0; i < CFG_NUM; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_AW'(i);
      cfg_data <= vals[i];
      shadow_cfg[i] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Presents one request, holds it until accepted, and records what it should produce.
  task automatic push_item(input script_item_t it, input logic typed, input draw_cmd_t fixed);
    draw_cmd_t cmd;
    bit has_cmd;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mode <= it.mode;
    in_draw_kind <= it.kind;
    in_target_reg <= it.tgt;
    in_alu_op <= it.op;
    in_operand_word <= it.operand;
    in_coord_x <= it.x;
    in_coord_y <= it.y;
    in_size_w <= it.w;
    in_size_h <= it.h;
    in_color <= it.color;
    in_text_flags <= it.flags;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_cmd = run_script_item(it, cmd);
    if (typed) pending_draw_cmds.push_back(fixed);
    else if (has_cmd) pending_draw_cmds.push_back(cmd);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_draw_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    draw_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_draw_cmds.size() == 0) begin
        $display("%0t: unexpected draw command, expected none, actual kind %0d fault %b",
                 $time, out_cmd_kind, out_fault);
        errors++;
      end else begin
        want = pending_draw_cmds.pop_front();
        check_field("cmd_kind", 32'(want.kind), 32'(out_cmd_kind));
        check_field("pos_x", 32'(want.px), 32'(out_pos_x));
        check_field("pos_y", 32'(want.py), 32'(out_pos_y));
        check_field("extent_w", 32'(want.ew), 32'(out_extent_w));
        check_field("extent_h", 32'(want.eh), 32'(out_extent_h));
        check_field("cmd_color", want.color, out_cmd_color);
        check_field("cmd_flags", want.flags, out_cmd_flags);
        check_field("fault", 32'(want.fault), 32'(out_fault));
        cmds_checked++;
        if (out_fault) faults_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run stopped at the cycle limit, %0d draw commands outstanding",
               $time, pending_draw_cmds.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r, ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = '0;
    in_draw_kind = '0;
    in_target_reg = '0;
    in_alu_op = '0;
    in_operand_word = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_size_w = '0;
    in_size_h = '0;
    in_color = '0;
    in_text_flags = '0;
    out_ready = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_cfg[i]) shadow_cfg[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_settings('{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                    16'h1234, 16'h5678, 16'hFFFF, 16'h0000});
    for (r = 0; r < NUM_DIRECTED; r++)
      push_item(script_table[r].item, script_table[r].typed, script_table[r].cmd);
    drain_block();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      load_settings(phase_settings(ph));
      idle_mode = idle_e'(ph % 4);
      repeat (ITEMS_PER_PHASE) push_item(random_item(), 1'b0, '0);
      drain_block();
    end

    $display("Sent %0d script requests across %0d register settings and four pacing modes",
             items_sent, NUM_PHASES + 1);
    $display("Checked %0d draw commands, %0d of them carrying a fault",
             cmds_checked, faults_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
sv/dsra_pkg.sv
sv/dsra_ram.sv
sv/dsra_alu.sv
sv/draw_script_register_alu.sv
tb/draw_script_register_alu_test.sv
